[sv/cr_pkg.sv]
package cr_pkg;

  // Coordinate width of the center fields; the radius is one bit narrower.
  localparam int COORD_BITS = 12;
  localparam int RAD_W      = COORD_BITS - 1;
  // Emitted pixel coordinates, two's complement.
  localparam int PT_W       = COORD_BITS + 2;
  // Signed decision value of the midpoint walk.
  localparam int DEC_W      = COORD_BITS + 2;

  // Eight symmetric pixels per step.
  localparam int PTS_PER_STEP = 8;
  localparam int IDX_W        = $clog2(PTS_PER_STEP);

  // Step queue between the front and the back.
  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
  localparam int Q_CW    = $clog2(Q_DEPTH + 1);

  // Request codes.
  localparam logic REQ_START = 1'b0;
  localparam logic REQ_STEP  = 1'b1;

  // One step of the walk: center and the offsets before the update.
  typedef struct packed {
    logic [COORD_BITS-1:0]        cx;
    logic [COORD_BITS-1:0]        cy;
    logic signed [COORD_BITS-1:0] x;
    logic signed [COORD_BITS-1:0] y;
    logic                         done;
  } step_rec_t;

endpackage

[sv/cr_front.sv]
module cr_front
  import cr_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  push,
  output logic                  full,
  input  logic                  in_req_type,
  input  logic [COORD_BITS-1:0] in_center_x,
  input  logic [COORD_BITS-1:0] in_center_y,
  input  logic [RAD_W-1:0]      in_radius,
  output logic                  q_wr,
  output step_rec_t             q_wdata,
  input  logic                  q_full
);

  logic                         active_r, active_nxt;
  logic [COORD_BITS-1:0]        cx_r, cx_nxt;
  logic [COORD_BITS-1:0]        cy_r, cy_nxt;
  logic signed [COORD_BITS-1:0] x_r, x_nxt;
  logic signed [COORD_BITS-1:0] y_r, y_nxt;
  logic [DEC_W-1:0]             dec_r, dec_nxt;

  logic                         accept;
  logic                         dec_neg;
  logic [DEC_W-1:0]             x_ext;
  logic [DEC_W-1:0]             y_ext;
  logic [DEC_W-1:0]             dec_step;
  logic signed [COORD_BITS-1:0] x_step;
  logic signed [COORD_BITS-1:0] y_step;
  logic                         step_done;

  // A beat is taken whenever the step queue has room.
  assign full   = q_full;
  assign accept = push && !q_full;

  // Midpoint update of the decision value and the offsets.
  assign dec_neg   = dec_r[DEC_W-1];
  assign x_ext     = {{(DEC_W-COORD_BITS){x_r[COORD_BITS-1]}}, x_r};
  assign y_ext     = {{(DEC_W-COORD_BITS){y_r[COORD_BITS-1]}}, y_r};
  assign dec_step  = dec_neg ? (dec_r + (x_ext << 2) + DEC_W'(6))
                             : (dec_r + ((x_ext - y_ext) << 2) + DEC_W'(10));
  assign x_step    = x_r + COORD_BITS'(1);
  assign y_step    = dec_neg ? y_r : (y_r - COORD_BITS'(1));
  assign step_done = (x_step > y_step);

  // Hand a step to the back part while a circle is in progress.
  assign q_wr         = accept && (in_req_type == REQ_STEP) && active_r;
  assign q_wdata.cx   = cx_r;
  assign q_wdata.cy   = cy_r;
  assign q_wdata.x    = x_r;
  assign q_wdata.y    = y_r;
  assign q_wdata.done = step_done;

  // Next walk state.
  always_comb begin
    active_nxt = active_r;
    cx_nxt     = cx_r;
    cy_nxt     = cy_r;
    x_nxt      = x_r;
    y_nxt      = y_r;
    dec_nxt    = dec_r;
    if (accept && (in_req_type == REQ_START)) begin
      active_nxt = 1'b1;
      cx_nxt     = in_center_x;
      cy_nxt     = in_center_y;
      x_nxt      = '0;
      y_nxt      = {1'b0, in_radius};
      dec_nxt    = DEC_W'(3) - {2'b00, in_radius, 1'b0};
    end else if (q_wr) begin
      active_nxt = !step_done;
      x_nxt      = x_step;
      y_nxt      = y_step;
      dec_nxt    = dec_step;
    end
  end

  // Walk state registers; only the active flag needs a reset.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
    end else begin
      active_r <= active_nxt;
    end
    cx_r  <= cx_nxt;
    cy_r  <= cy_nxt;
    x_r   <= x_nxt;
    y_r   <= y_nxt;
    dec_r <= dec_nxt;
  end

endmodule

[sv/cr_step_fifo.sv]
module cr_step_fifo
  import cr_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      wr,
  input  step_rec_t wdata,
  output logic      q_full,
  output logic      q_valid,
  output step_rec_t rdata,
  input  logic      rd
);

  step_rec_t       mem_r [Q_DEPTH];
  logic [Q_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [Q_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [Q_CW-1:0] count_r, count_nxt;
  logic            do_wr;
  logic            do_rd;

  assign q_full  = (count_r == Q_CW'(Q_DEPTH));
  assign q_valid = (count_r != '0);
  assign rdata   = mem_r[rd_ptr_r];
  assign do_wr   = wr && !q_full;
  assign do_rd   = rd && q_valid;

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_wr) begin
      wr_ptr_nxt = (wr_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : (wr_ptr_r + Q_AW'(1));
    end
    if (do_rd) begin
      rd_ptr_nxt = (rd_ptr_r == Q_AW'(Q_DEPTH - 1)) ? '0 : (rd_ptr_r + Q_AW'(1));
    end
    if (do_wr && !do_rd) begin
      count_nxt = count_r + Q_CW'(1);
    end else if (do_rd && !do_wr) begin
      count_nxt = count_r - Q_CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

[sv/cr_back.sv]
module cr_back
  import cr_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 q_valid,
  input  step_rec_t            q_rdata,
  output logic                 q_rd,
  output logic                 empty,
  input  logic                 pop,
  output logic signed [PT_W-1:0] out_point_x,
  output logic signed [PT_W-1:0] out_point_y,
  output logic                 out_last_of_step,
  output logic                 out_circle_done
);

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [PT_W-1:0]  px_r;
  logic [PT_W-1:0]  py_r;
  logic             last_r;
  logic             done_r;

  logic             load;
  logic             is_last;
  logic [COORD_BITS-1:0] dx;
  logic [COORD_BITS-1:0] dy;
  logic [PT_W-1:0]  dx_ext;
  logic [PT_W-1:0]  dy_ext;
  logic [PT_W-1:0]  px_nxt;
  logic [PT_W-1:0]  py_nxt;

  // The output register takes a new pixel when it is free or being popped.
  assign load    = q_valid && (!out_valid_r || pop);
  assign is_last = (idx_r == IDX_W'(PTS_PER_STEP - 1));
  assign q_rd    = load && is_last;

  // Octant selection: the high index bit swaps the offsets, the two low
  // bits negate the column and the row term.
  assign dx     = idx_r[2] ? q_rdata.y : q_rdata.x;
  assign dy     = idx_r[2] ? q_rdata.x : q_rdata.y;
  assign dx_ext = {{(PT_W-COORD_BITS){dx[COORD_BITS-1]}}, dx};
  assign dy_ext = {{(PT_W-COORD_BITS){dy[COORD_BITS-1]}}, dy};
  assign px_nxt = {{(PT_W-COORD_BITS){1'b0}}, q_rdata.cx}
                  + (idx_r[1] ? (-dx_ext) : dx_ext);
  assign py_nxt = {{(PT_W-COORD_BITS){1'b0}}, q_rdata.cy}
                  + (idx_r[0] ? (-dy_ext) : dy_ext);

  // Pixel index and output valid.
  always_comb begin
    idx_nxt       = idx_r;
    out_valid_nxt = out_valid_r;
    if (load) begin
      idx_nxt       = is_last ? '0 : (idx_r + IDX_W'(1));
      out_valid_nxt = 1'b1;
    end else if (pop) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load) begin
      px_r   <= px_nxt;
      py_r   <= py_nxt;
      last_r <= is_last;
      done_r <= is_last && q_rdata.done;
    end
  end

  assign empty            = !out_valid_r;
  assign out_point_x      = px_r;
  assign out_point_y      = py_r;
  assign out_last_of_step = last_r;
  assign out_circle_done  = done_r;

endmodule

[sv/circle_rasterizer.sv]
// Midpoint circle generator: a start beat loads center and radius, each step beat
// yields eight symmetric pixels. A beat is taken while the step queue has room;
// a step passes through the step queue and then the output register, one pixel
// at a time. The output register delivers one pixel per cycle while it is popped
// and the step queue holds a step, so a step yields eight pixels on the result side.
// Synchronous active-low reset leaves the block idle with the step queue and the output register empty.
module circle_rasterizer
  import cr_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   push,
  output logic                   full,
  input  logic                   in_req_type,
  input  logic [COORD_BITS-1:0]  in_center_x,
  input  logic [COORD_BITS-1:0]  in_center_y,
  input  logic [RAD_W-1:0]       in_radius,
  output logic                   empty,
  input  logic                   pop,
  output logic signed [PT_W-1:0] out_point_x,
  output logic signed [PT_W-1:0] out_point_y,
  output logic                   out_last_of_step,
  output logic                   out_circle_done
);

  logic      q_wr;
  logic      q_full;
  logic      q_valid;
  logic      q_rd;
  step_rec_t q_wdata;
  step_rec_t q_rdata;

  // Front: request decode and the midpoint walk.
  cr_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .push        (push),
    .full        (full),
    .in_req_type (in_req_type),
    .in_center_x (in_center_x),
    .in_center_y (in_center_y),
    .in_radius   (in_radius),
    .q_wr        (q_wr),
    .q_wdata     (q_wdata),
    .q_full      (q_full)
  );

  // Queue of pending steps.
  cr_step_fifo u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr      (q_wr),
    .wdata   (q_wdata),
    .q_full  (q_full),
    .q_valid (q_valid),
    .rdata   (q_rdata),
    .rd      (q_rd)
  );

  // Back: pixel expansion and output register.
  cr_back u_back (
    .clk              (clk),
    .rst_n            (rst_n),
    .q_valid          (q_valid),
    .q_rdata          (q_rdata),
    .q_rd             (q_rd),
    .empty            (empty),
    .pop              (pop),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

endmodule

[sim/testbench.sv]
`timescale 1ns / 100ps

module testbench;
  import cr_pkg::*;

  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 10;
  localparam int PHASE_BEATS = 20;
  localparam int NUM_ROWS    = 23;

  // One expected pixel as it leaves the block.
  typedef struct packed {
    logic signed [PT_W-1:0] px;
    logic signed [PT_W-1:0] py;
    logic                   last;
    logic                   done;
  } pixel_t;

  // One directed beat; rows with typed set carry their pixels in place.
  // A typed step row yields count copies of (tx, ty) ending a step.
  typedef struct packed {
    logic                   req;
    logic [COORD_BITS-1:0]  cx;
    logic [COORD_BITS-1:0]  cy;
    logic [RAD_W-1:0]       r;
    logic                   typed;
    logic [3:0]             count;
    logic signed [PT_W-1:0] tx;
    logic signed [PT_W-1:0] ty;
    logic                   tdone;
  } stim_row_t;

  localparam stim_row_t BEAT_TABLE [NUM_ROWS] = '{
    // Step right after reset: the block is idle and yields nothing.
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    // Zero radius at the origin: the center eight times, then finished.
    '{REQ_START, 12'd0,    12'd0,    11'd0,    1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd4095, 12'd4095, 11'd2047, 1'b1, 4'd8, 14'sd0,    14'sd0,    1'b1},
    // Step after the circle has finished.
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    // Zero radius at the far corner.
    '{REQ_START, 12'd4095, 12'd4095, 11'd0,    1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd8, 14'sd4095, 14'sd4095, 1'b1},
    // Largest radius at the origin reaches the most negative pixels.
    '{REQ_START, 12'd0,    12'd0,    11'd2047, 1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    // A start while a circle is active abandons it.
    '{REQ_START, 12'd4095, 12'd0,    11'd2047, 1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    // Radius one finishes in a single step.
    '{REQ_START, 12'd2048, 12'd2048, 11'd1,    1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    // A small circle walked to its end, both decision branches taken.
    '{REQ_START, 12'd1234, 12'd3000, 11'd5,    1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0},
    // Alternating bit patterns on all start fields.
    '{REQ_START, 12'h555,  12'hAAA,  11'h2AA,  1'b1, 4'd0, 14'sd0,    14'sd0,    1'b0},
    '{REQ_STEP,  12'd0,    12'd0,    11'd0,    1'b0, 4'd0, 14'sd0,    14'sd0,    1'b0}
  };

  logic                   clk;
  logic                   rst_n;
  logic                   push;
  logic                   full;
  logic                   in_req_type;
  logic [COORD_BITS-1:0]  in_center_x;
  logic [COORD_BITS-1:0]  in_center_y;
  logic [RAD_W-1:0]       in_radius;
  logic                   empty;
  logic                   pop;
  logic signed [PT_W-1:0] out_point_x;
  logic signed [PT_W-1:0] out_point_y;
  logic                   out_last_of_step;
  logic                   out_circle_done;

  // Side information travelling with each input beat.
  logic beat_typed;
  int   beat_row;

  // Circle walk state as the block should hold it.
  logic                   walk_active;
  logic [COORD_BITS-1:0]  walk_cx;
  logic [COORD_BITS-1:0]  walk_cy;
  int                     walk_x;
  int                     walk_y;
  logic signed [DEC_W-1:0] walk_dec;
  pixel_t                 walk_pixels [PTS_PER_STEP];

  pixel_t pixels_due [$];
  int     failures;
  int     useful_beats;
  int     cycle_count;
  int     send_idle_pct;
  int     pop_stall_pct;
  int     hold_request;

  circle_rasterizer i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .push             (push),
    .full             (full),
    .in_req_type      (in_req_type),
    .in_center_x      (in_center_x),
    .in_center_y      (in_center_y),
    .in_radius        (in_radius),
    .empty            (empty),
    .pop              (pop),
    .out_point_x      (out_point_x),
    .out_point_y      (out_point_y),
    .out_last_of_step (out_last_of_step),
    .out_circle_done  (out_circle_done)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pixel_t pixel_at(input int px, input int py, input logic last,
                                      input logic done);
    pixel_t p;
    p.px   = PT_W'(px);
    p.py   = PT_W'(py);
    p.last = last;
    p.done = done;
    return p;
  endfunction

  // Advances the midpoint walk by one beat and fills walk_pixels.
  // Returns the number of pixels the beat yields.
  function automatic int walk_octant(input logic req, input logic [COORD_BITS-1:0] cx,
                                     input logic [COORD_BITS-1:0] cy,
                                     input logic [RAD_W-1:0] r);
    int   x;
    int   y;
    int   ox;
    int   oy;
    logic fin;
    if (req == REQ_START) begin
      walk_cx     = cx;
      walk_cy     = cy;
      walk_x      = 0;
      walk_y      = int'(r);
      walk_dec    = DEC_W'(3 - 2 * int'(r));
      walk_active = 1'b1;
      return 0;
    end
    if (!walk_active) return 0;
    x  = walk_x;
    y  = walk_y;
    ox = int'(walk_cx);
    oy = int'(walk_cy);
    // Straight across while the decision is negative, else diagonal.
    if (walk_dec < 0) begin
      walk_dec = DEC_W'(int'(walk_dec) + 4 * x + 6);
    end else begin
      walk_dec = DEC_W'(int'(walk_dec) + 4 * (x - y) + 10);
      walk_y   = y - 1;
    end
    walk_x = x + 1;
    fin    = (walk_x > walk_y);
    if (fin) walk_active = 1'b0;
    walk_pixels[0] = pixel_at(ox + x, oy + y, 1'b0, 1'b0);
    walk_pixels[1] = pixel_at(ox + x, oy - y, 1'b0, 1'b0);
    walk_pixels[2] = pixel_at(ox - x, oy + y, 1'b0, 1'b0);
    walk_pixels[3] = pixel_at(ox - x, oy - y, 1'b0, 1'b0);
    walk_pixels[4] = pixel_at(ox + y, oy + x, 1'b0, 1'b0);
    walk_pixels[5] = pixel_at(ox + y, oy - x, 1'b0, 1'b0);
    walk_pixels[6] = pixel_at(ox - y, oy + x, 1'b0, 1'b0);
    walk_pixels[7] = pixel_at(ox - y, oy - x, 1'b1, fin);
    return PTS_PER_STEP;
  endfunction

  // Input beats feed the walk; result beats are checked against the oldest pixel due.
  always @(posedge clk) begin
    int        n;
    pixel_t    due;
    stim_row_t row;
    if (rst_n && push && !full) begin
      n = walk_octant(in_req_type, in_center_x, in_center_y, in_radius);
      if (in_req_type == REQ_START || n > 0) useful_beats++;
      if (beat_typed) begin
        row = BEAT_TABLE[beat_row];
        for (int k = 0; k < int'(row.count); k++)
          pixels_due.push_back(pixel_at(int'(row.tx), int'(row.ty), k == PTS_PER_STEP - 1,
                                        (k == PTS_PER_STEP - 1) && row.tdone));
      end else begin
        for (int k = 0; k < n; k++) pixels_due.push_back(walk_pixels[k]);
      end
    end
    if (rst_n && pop && !empty) begin
      if (pixels_due.size() == 0) begin
        failures++;
        if (failures <= MAX_REPORTS)
          $display("pixel with nothing due: x=%0d y=%0d last=%0b done=%0b",
                   out_point_x, out_point_y, out_last_of_step, out_circle_done);
      end else begin
        due = pixels_due.pop_front();
        if (out_point_x !== due.px || out_point_y !== due.py ||
            out_last_of_step !== due.last || out_circle_done !== due.done) begin
          failures++;
          if (failures <= MAX_REPORTS)
            $display("pixel mismatch: expected x=%0d y=%0d last=%0b done=%0b,",
                     due.px, due.py, due.last, due.done,
                     " got x=%0d y=%0d last=%0b done=%0b",
                     out_point_x, out_point_y, out_last_of_step, out_circle_done);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Result side: random stalls, plus a long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    pop <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (hold_request != 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        hold_left--;
        pop <= 1'b0;
      end else begin
        pop <= ($urandom_range(99) >= pop_stall_pct);
      end
    end
  end

  // Offers one input beat and returns once it has been taken.
  task automatic offer(input logic req, input logic [COORD_BITS-1:0] cx,
                       input logic [COORD_BITS-1:0] cy, input logic [RAD_W-1:0] r,
                       input logic typed, input int row);
    while ($urandom_range(99) < send_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push        <= 1'b1;
    in_req_type <= req;
    in_center_x <= cx;
    in_center_y <= cy;
    in_radius   <= r;
    beat_typed  <= typed;
    beat_row    <= row;
    @(posedge clk);
    while (full) @(posedge clk);
  endtask

  // Holds the input side quiet until every pixel due has come out.
  task automatic drain;
    push <= 1'b0;
    @(posedge clk);
    while (pixels_due.size() != 0) @(posedge clk);
  endtask

  function automatic logic [RAD_W-1:0] pick_radius;
    int pick;
    pick = $urandom_range(99);
    if (pick < 80) return RAD_W'($urandom_range(12));
    if (pick < 95) return RAD_W'($urandom_range(60));
    return RAD_W'($urandom);
  endfunction

  // Random circles, mostly walked to their end, with stray and cut-short beats mixed in.
  task automatic run_circles(input int goal);
    int               pick;
    int               steps;
    logic [RAD_W-1:0] r;
    while (useful_beats < goal) begin
      pick = $urandom_range(99);
      if (pick < 8) begin
        offer(REQ_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_W'($urandom),
              1'b0, 0);
      end else if (pick < 12) begin
        offer(REQ_START, COORD_BITS'($urandom), COORD_BITS'($urandom), pick_radius(),
              1'b0, 0);
      end else begin
        r = pick_radius();
        offer(REQ_START, COORD_BITS'($urandom), COORD_BITS'($urandom), r, 1'b0, 0);
        steps = int'(r) * 3 / 4 + 1;
        if (steps > 14) steps = 14;
        if ($urandom_range(99) < 15) steps = $urandom_range(steps);
        repeat (steps)
          offer(REQ_STEP, COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_W'($urandom),
                1'b0, 0);
      end
    end
  endtask

  initial begin
    stim_row_t row;
    failures      = 0;
    useful_beats  = 0;
    cycle_count   = 0;
    send_idle_pct = 0;
    pop_stall_pct = 0;
    hold_request  = 0;
    walk_active   = 1'b0;
    walk_cx       = '0;
    walk_cy       = '0;
    walk_x        = 0;
    walk_y        = 0;
    walk_dec      = '0;
    rst_n       <= 1'b0;
    push        <= 1'b0;
    in_req_type <= REQ_START;
    in_center_x <= '0;
    in_center_y <= '0;
    in_radius   <= '0;
    beat_typed  <= 1'b0;
    beat_row    <= 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed beats from the table.
    for (int i = 0; i < NUM_ROWS; i++) begin
      row = BEAT_TABLE[i];
      offer(row.req, row.cx, row.cy, row.r, row.typed, i);
    end
    drain();

    // Back-pressure: the result side holds off while steps keep coming.
    hold_request = 250;
    offer(REQ_START, COORD_BITS'($urandom), COORD_BITS'($urandom), RAD_W'(30), 1'b0, 0);
    repeat (16) offer(REQ_STEP, '0, '0, '0, 1'b0, 0);
    drain();

    // Random circles under each idling pattern.
    run_circles(useful_beats + PHASE_BEATS);
    drain();
    send_idle_pct = 88;
    run_circles(useful_beats + PHASE_BEATS);
    drain();
    send_idle_pct = 0;
    pop_stall_pct = 88;
    run_circles(useful_beats + PHASE_BEATS);
    drain();
    send_idle_pct = 32;
    pop_stall_pct = 32;
    run_circles(useful_beats + PHASE_BEATS);
    drain();

    // Let any stray pixel surface before the verdict.
    repeat (40) @(posedge clk);
    if (pixels_due.size() != 0) failures++;
    if (failures == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
